### hw/rtl/tsrm_pkg.sv
// tsrm_pkg: constants, types and helpers of the ranging-sensor register model.
// No dependencies; imported by every module of the block and by the bench.
`timescale 1ns / 1ps

package tsrm_pkg;

    // Transaction kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Register map
    localparam logic [15:0] ADDR_STATUS = 16'h00E5;
    localparam logic [15:0] ADDR_READY  = 16'h0031;
    localparam logic [15:0] ADDR_START  = 16'h0087;
    localparam logic [15:0] ADDR_HIST   = 16'h0088;
    localparam logic [15:0] ADDR_OSC    = 16'h00DE;

    // Histogram block layout
    localparam logic [7:0] HIST_LEN       = 8'd83;
    localparam logic [7:0] HIST_BIN_FIRST = 8'd6;
    localparam logic [7:0] HIST_BIN_END   = 8'd78;
    localparam logic [7:0] HIST_CAL_HI    = 8'd81;
    localparam logic [7:0] HIST_CAL_LO    = 8'd82;
    localparam logic [7:0] HIST_HDR0      = 8'h03;
    localparam logic [7:0] HIST_HDR1      = 8'h09;
    localparam logic [7:0] HIST_HDR5      = 8'hC0;
    localparam logic [4:0] HIST_LAST_BIN  = 5'd23;

    // Fixed read bytes
    localparam logic [7:0] STATUS_BYTE0 = 8'h01;
    localparam logic [7:0] OSC_BYTE0    = 8'h06;

    // Peak placement, phase in 10-bit fixed point
    localparam logic [10:0] DIST_MAX    = 11'd1400;
    localparam logic [13:0] PHASE_SCALE = 14'd10895;
    // 22528*1024 - 1024*1024
    localparam logic [25:0] PHASE_BASE  = 26'd22020096;
    localparam logic [20:0] PHASE_HALF  = 21'h100000;
    localparam logic [5:0]  BIN_OFFSET  = 6'd4;
    localparam logic [5:0]  BIN_LO      = 6'd6;
    localparam logic [5:0]  BIN_HI      = 6'd22;

    // Bin levels
    localparam logic [10:0] LEVEL_FLOOR = 11'd40;
    localparam logic [10:0] LEVEL_SIDE  = 11'd240;   // floor + side
    localparam logic [10:0] LEVEL_PEAK  = 11'd2040;  // floor + peak

    typedef logic [4:0]  bin_idx_t;
    typedef logic [10:0] bin_val_t;

    function automatic bin_val_t bin_value(input bin_idx_t k, input bin_idx_t b0);
        bin_val_t v;
        begin
            if (k == b0)
            begin
                v = LEVEL_PEAK;
            end
            else if ((k + 5'd1 == b0) || (k == b0 + 5'd1))
            begin
                v = LEVEL_SIDE;
            end
            else
            begin
                v = LEVEL_FLOOR;
            end
            return v;
        end
    endfunction

endpackage

### hw/rtl/tsrm_if.sv
// tsrm_if: valid/ready channel interfaces for requests, responses and configuration.
// No dependencies; its widths agree with tsrm_pkg by house consistency only.
`timescale 1ns / 1ps

interface tsrm_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        pointer_present;
    logic [15:0] reg_pointer;
    logic [7:0]  write_len;
    logic [7:0]  read_len;
    logic [7:0]  read_offset;

    modport source (output valid, command, pointer_present, reg_pointer,
                    write_len, read_len, read_offset, input ready);
    modport sink   (input valid, command, pointer_present, reg_pointer,
                    write_len, read_len, read_offset, output ready);
endinterface

interface tsrm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] frame_count;

    modport source (output valid, read_data, frame_count, input ready);
    modport sink   (input valid, read_data, frame_count, output ready);
endinterface

interface tsrm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance_mm;

    modport source (output valid, distance_mm, input ready);
    modport sink   (input valid, distance_mm, output ready);
endinterface

### hw/rtl/tsrm_peak_bin.sv
// tsrm_peak_bin: registered peak-bin position from the configured distance.
// Depends on tsrm_pkg.
`timescale 1ns / 1ps

module tsrm_peak_bin
    import tsrm_pkg::*;
(
    input  logic        clk,
    input  logic [15:0] distance_mm,
    output bin_idx_t    peak_bin
);

    logic [10:0] dist_clamped;
    logic [24:0] phase_prod;
    logic [25:0] phase;
    logic [4:0]  quot;
    logic [20:0] rem;
    logic        round_up;
    logic [5:0]  bin_raw;
    bin_idx_t    peak_next;
    bin_idx_t    peak_reg;

    always_comb
    begin
        dist_clamped = (distance_mm > 16'(DIST_MAX)) ? DIST_MAX : distance_mm[10:0];
        phase_prod   = 25'(dist_clamped) * 25'(PHASE_SCALE);
        phase        = PHASE_BASE + 26'(phase_prod);
        quot         = phase[25:21];
        rem          = phase[20:0];
        // round half to even
        round_up     = (rem > PHASE_HALF) || ((rem == PHASE_HALF) && quot[0]);
        bin_raw      = 6'(quot) + 6'(round_up) + BIN_OFFSET;
        if (bin_raw < BIN_LO)
        begin
            peak_next = BIN_LO[4:0];
        end
        else if (bin_raw > BIN_HI)
        begin
            peak_next = BIN_HI[4:0];
        end
        else
        begin
            peak_next = bin_raw[4:0];
        end
    end

    always_ff @(posedge clk)
    begin
        peak_reg <= peak_next;
    end

    assign peak_bin = peak_reg;

endmodule

### hw/rtl/tof_sensor_register_model.sv
// tof_sensor_register_model: top level of the ranging-sensor register model.
// Depends on tsrm_pkg, tsrm_if (channel interfaces) and tsrm_peak_bin.
`timescale 1ns / 1ps

// Register model of a time-of-flight ranging sensor addressed through a 16-bit
// register pointer. Each request transaction is a bus write or one byte of a bus
// read; it may latch a new pointer first. A write whose span covers the
// mode-start register advances the 8-bit stream count; reads return status
// bytes, the oscillator value or the 83-byte histogram block built around a
// peak bin placed from distance_mm. Every request yields exactly one response.
// Throughput is one transaction per clock while responses are taken. A request
// passes an input stage register and then the response register, which drives
// rsp.valid; a response waiting for rsp.ready holds the next one in the stage.
// The pointer and stream count are updated as a transaction moves from the input
// stage into the response register, so back-to-back transactions see each
// other's effect. The peak bin is derived from distance_mm through one registered
// multiply that loads at the same edge as a configuration write; write
// distance_mm only while no transaction is in flight. The response register lets
// a new request be taken while a finished response waits for rsp.ready.
module tof_sensor_register_model
    import tsrm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tsrm_req_if.sink   req,
    tsrm_rsp_if.source rsp,
    tsrm_cfg_if.sink   cfg
);

    // Configuration
    logic [15:0] distance_reg;
    logic [15:0] distance_sel;
    bin_idx_t    peak_bin;

    // Input stage
    logic        stage_valid_reg;
    logic        stage_valid_next;
    logic        stage_cmd_reg;
    logic        stage_ptr_present_reg;
    logic [15:0] stage_ptr_reg;
    logic [7:0]  stage_wlen_reg;
    logic [7:0]  stage_rlen_reg;
    logic [7:0]  stage_roff_reg;

    // Architectural state
    logic [15:0] pointer_reg;
    logic [15:0] pointer_next;
    logic [7:0]  frame_cnt_reg;
    logic [7:0]  frame_cnt_next;

    // Response register
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic [7:0]  rsp_data_reg;
    logic [7:0]  rsp_count_reg;

    // Handshake
    logic        req_fire;
    logic        rsp_take;
    logic        proc_fire;

    // Datapath
    logic [15:0] span;
    logic [15:0] span_end;
    logic        start_hit;
    logic [7:0]  hist_byte;
    logic [7:0]  bin_off;
    logic [15:0] div_prod;
    bin_idx_t    bin_k;
    logic [1:0]  bin_j;
    bin_val_t    bin_v;
    bin_val_t    bin_last;
    logic [7:0]  data_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_reg <= '0;
        end
        else if (cfg.valid)
        begin
            distance_reg <= cfg.distance_mm;
        end
    end

    // Peak bin follows a write at the same edge as the distance register
    assign distance_sel = cfg.valid ? cfg.distance_mm : distance_reg;

    tsrm_peak_bin u_peak_bin
    (
        .clk         (clk),
        .distance_mm (distance_sel),
        .peak_bin    (peak_bin)
    );

    // Flow control: the stage drains whenever the response register can take it
    assign rsp_take  = !rsp_valid_reg || rsp.ready;
    assign proc_fire = stage_valid_reg && rsp_take;
    assign req.ready = !stage_valid_reg || rsp_take;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (req_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            stage_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (proc_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            stage_cmd_reg         <= req.command;
            stage_ptr_present_reg <= req.pointer_present;
            stage_ptr_reg         <= req.reg_pointer;
            stage_wlen_reg        <= req.write_len;
            stage_rlen_reg        <= req.read_len;
            stage_roff_reg        <= req.read_offset;
        end
    end

    // Pointer latch and mode-start detection
    always_comb
    begin
        pointer_next = stage_ptr_present_reg ? stage_ptr_reg : pointer_reg;
        span         = (stage_wlen_reg >= 8'd2) ? 16'(stage_wlen_reg - 8'd2) : 16'd0;
        span_end     = pointer_next + span;  // wraps modulo 2^16
        start_hit    = (pointer_next <= ADDR_START) && (ADDR_START < span_end);
        frame_cnt_next = frame_cnt_reg;
        if ((stage_cmd_reg == CMD_WRITE) && start_hit)
        begin
            frame_cnt_next = frame_cnt_reg + 8'd1;
        end
    end

    // Histogram byte: bins are three bytes each; /3 by reciprocal (exact for < 96)
    always_comb
    begin
        bin_off  = stage_roff_reg - HIST_BIN_FIRST;
        div_prod = 16'(bin_off) * 16'd171;
        bin_k    = div_prod[13:9];
        bin_j    = 2'(bin_off - 8'(3 * bin_k));
        bin_v    = bin_value(bin_k, peak_bin);
        bin_last = bin_value(HIST_LAST_BIN, peak_bin);
        hist_byte = 8'h00;
        case (stage_roff_reg)
            8'd0:        hist_byte = HIST_HDR0;
            8'd1:        hist_byte = HIST_HDR1;
            8'd3:        hist_byte = frame_cnt_reg;
            8'd5:        hist_byte = HIST_HDR5;
            HIST_CAL_HI: hist_byte = {2'b00, bin_last[7:2]};
            HIST_CAL_LO: hist_byte = {6'b0, bin_last[1:0]};
            default:
            begin
                if ((stage_roff_reg >= HIST_BIN_FIRST) && (stage_roff_reg < HIST_BIN_END))
                begin
                    case (bin_j)
                        2'd1:    hist_byte = {5'b0, bin_v[10:8]};
                        2'd2:    hist_byte = bin_v[7:0];
                        default: hist_byte = 8'h00;   // top byte of a 24-bit bin
                    endcase
                end
            end
        endcase
    end

    // Read byte selection
    always_comb
    begin
        data_next = 8'h00;
        if ((stage_cmd_reg == CMD_READ) && (stage_roff_reg < stage_rlen_reg))
        begin
            if (pointer_next == ADDR_STATUS)
            begin
                data_next = (stage_roff_reg == 8'd0) ? STATUS_BYTE0 : 8'h00;
            end
            else if (pointer_next == ADDR_OSC)
            begin
                if ((stage_rlen_reg >= 8'd2) && (stage_roff_reg == 8'd0))
                begin
                    data_next = OSC_BYTE0;
                end
            end
            else if (pointer_next == ADDR_HIST)
            begin
                if (stage_rlen_reg >= HIST_LEN)
                begin
                    data_next = hist_byte;
                end
            end
            // ready register and everything else read zero
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            pointer_reg     <= '0;
            frame_cnt_reg   <= 8'hFF;   // first start write wraps to zero
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (proc_fire)
            begin
                pointer_reg   <= pointer_next;
                frame_cnt_reg <= frame_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            rsp_data_reg  <= data_next;
            rsp_count_reg <= frame_cnt_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = rsp_data_reg;
    assign rsp.frame_count = rsp_count_reg;

    // Checks
    a_proc_fills_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |=> rsp_valid_reg)
        else $error("processed transaction did not reach the response register");

    a_write_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && (stage_cmd_reg == CMD_WRITE)) |=> (rsp_data_reg == 8'h00))
        else $error("write acknowledge carried non-zero data");

    a_count_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(proc_fire && (stage_cmd_reg == CMD_WRITE)) |=> $stable(frame_cnt_reg))
        else $error("stream count moved without a write");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (stage_valid_reg && rsp_valid_reg))
        else $error("request stalled with room in the pipeline");

endmodule

### bench/tsrm_response_checker.sv
// tsrm_response_checker: passive scoreboard for the ranging-sensor register model.
// Watches the request, response and configuration channels, predicts every response in
// order and counts mismatches. Depends on tsrm_pkg for the register map and transaction kinds.
`timescale 1ns / 1ps

module tsrm_response_checker
    import tsrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic        req_command,
    input  logic        req_pointer_present,
    input  logic [15:0] req_reg_pointer,
    input  logic [7:0]  req_write_len,
    input  logic [7:0]  req_read_len,
    input  logic [7:0]  req_read_offset,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [7:0]  rsp_read_data,
    input  logic [7:0]  rsp_frame_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_distance_mm,
    output int          mismatches,
    output int          outstanding,
    output int          responses
);

    // Peak placement, phase in 10-bit fixed point
    localparam logic [31:0] PHASE_ORIGIN = 32'd23068672;  // 22528 * 1024
    localparam logic [31:0] PHASE_STEP   = 32'd10895;
    localparam logic [31:0] HALF_BIN     = 32'd1048576;   // 1024 * 1024
    localparam logic [20:0] ROUND_TIE    = 21'h100000;
    localparam logic [15:0] RANGE_LIMIT  = 16'd1400;
    localparam int          PEAK_LOWEST  = 6;
    localparam int          PEAK_HIGHEST = 22;
    localparam int          LAST_BIN     = 23;

    localparam int LEVEL_BASE = 40;
    localparam int LEVEL_TOP  = 2040;
    localparam int LEVEL_NEAR = 240;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] frame_count;
    } response_t;

    response_t   expected_responses[$];
    logic [15:0] live_pointer;
    logic [7:0]  stream_frames;
    logic [15:0] range_setting;
    int          failures;
    int          seen;

    function automatic int peak_bin(input logic [15:0] range_mm);
        logic [31:0] d;
        logic [31:0] phase;
        logic [31:0] q;
        logic [20:0] r;
        int          b;
        d = (range_mm > RANGE_LIMIT) ? {16'd0, RANGE_LIMIT} : {16'd0, range_mm};
        phase = PHASE_ORIGIN + d * PHASE_STEP - HALF_BIN;
        q = phase >> 21;
        r = phase[20:0];
        if (r > ROUND_TIE || (r == ROUND_TIE && q[0]))
        begin
            q = q + 32'd1;
        end
        b = int'(q) + 4;
        if (b < PEAK_LOWEST)
        begin
            b = PEAK_LOWEST;
        end
        if (b > PEAK_HIGHEST)
        begin
            b = PEAK_HIGHEST;
        end
        return b;
    endfunction

    function automatic int bin_level(input int k, input int peak);
        if (k == peak)
        begin
            return LEVEL_TOP;
        end
        if (k + 1 == peak || k == peak + 1)
        begin
            return LEVEL_NEAR;
        end
        return LEVEL_BASE;
    endfunction

    function automatic logic [7:0] histogram_byte(input int off, input int peak,
                                                  input logic [7:0] frames);
        logic [23:0] level;
        logic [7:0]  b;
        b = 8'h00;
        level = 24'(bin_level(LAST_BIN, peak));
        if (off == 0)
        begin
            b = 8'h03;
        end
        else if (off == 1)
        begin
            b = 8'h09;
        end
        else if (off == 3)
        begin
            b = frames;
        end
        else if (off == 5)
        begin
            b = 8'hC0;
        end
        else if (off >= 6 && off < 78)
        begin
            level = 24'(bin_level((off - 6) / 3, peak));
            case ((off - 6) % 3)
                0:       b = level[23:16];
                1:       b = level[15:8];
                default: b = level[7:0];
            endcase
        end
        else if (off == 81)
        begin
            b = {2'b00, level[7:2]};
        end
        else if (off == 82)
        begin
            b = {6'd0, level[1:0]};
        end
        return b;
    endfunction

    function automatic logic [7:0] read_byte(input logic [15:0] ptr, input logic [7:0] rlen,
                                             input logic [7:0] roff, input logic [15:0] range_mm,
                                             input logic [7:0] frames);
        if (roff >= rlen)
        begin
            return 8'h00;
        end
        case (ptr)
            ADDR_STATUS: return (roff == 8'd0) ? 8'h01 : 8'h00;
            ADDR_OSC:    return (rlen >= 8'd2 && roff == 8'd0) ? 8'h06 : 8'h00;
            ADDR_HIST:   return (rlen >= HIST_LEN) ?
                                histogram_byte(int'(roff), peak_bin(range_mm), frames) : 8'h00;
            default:     return 8'h00;
        endcase
    endfunction

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= 10)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        response_t   predicted;
        logic [15:0] span;
        logic [15:0] span_end;
        if (!rst_n)
        begin
            expected_responses.delete();
            live_pointer  = 16'h0000;
            stream_frames = 8'hFF;
            range_setting = 16'd0;
            failures      = 0;
            seen          = 0;
            mismatches  <= 0;
            outstanding <= 0;
            responses   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                range_setting = cfg_distance_mm;
            end

            if (rsp_valid && rsp_ready)
            begin
                seen++;
                if (expected_responses.size() == 0)
                begin
                    report_failure($sformatf("response with nothing expected: data %02h count %02h",
                                             rsp_read_data, rsp_frame_count));
                end
                else
                begin
                    predicted = expected_responses.pop_front();
                    if (rsp_read_data !== predicted.read_data)
                    begin
                        report_failure($sformatf("response %0d read_data expected %02h got %02h",
                                                 seen, predicted.read_data, rsp_read_data));
                    end
                    if (rsp_frame_count !== predicted.frame_count)
                    begin
                        report_failure($sformatf("response %0d frame_count expected %02h got %02h",
                                                 seen, predicted.frame_count, rsp_frame_count));
                    end
                end
            end

            if (req_valid && req_ready)
            begin
                if (req_pointer_present)
                begin
                    live_pointer = req_reg_pointer;
                end
                predicted.read_data = 8'h00;
                if (req_command == CMD_WRITE)
                begin
                    span = (req_write_len >= 8'd2) ? {8'd0, req_write_len - 8'd2} : 16'd0;
                    span_end = live_pointer + span;
                    if (live_pointer <= ADDR_START && ADDR_START < span_end)
                    begin
                        stream_frames = stream_frames + 8'd1;
                    end
                end
                else
                begin
                    predicted.read_data = read_byte(live_pointer, req_read_len, req_read_offset,
                                                    range_setting, stream_frames);
                end
                predicted.frame_count = stream_frames;
                expected_responses.push_back(predicted);
            end

            mismatches  <= failures;
            outstanding <= expected_responses.size();
            responses   <= seen;
        end
    end

endmodule

### bench/tof_sensor_register_model_tb.sv
// tof_sensor_register_model_tb: top level of the register-model testbench.
// Drives request and configuration traffic, throttles the response side and reports the
// verdict. Depends on tsrm_pkg, tsrm_if, the block itself and tsrm_response_checker.
`timescale 1ns / 1ps

module tof_sensor_register_model_tb;
    import tsrm_pkg::*;

    // Random traffic volume, split evenly over the distance settings
    localparam int RANDOM_ITEMS     = 800;
    localparam int SETTINGS_COUNT   = 8;
    // Response-side hold-off long enough to back the block up into its request port
    localparam int LONG_HOLD_CYCLES = 120;
    // Settling time after the last response
    localparam int TAIL_CYCLES      = 10;

    logic clk;
    logic rst_n;

    tsrm_req_if req_ch ();
    tsrm_rsp_if rsp_ch ();
    tsrm_cfg_if cfg_ch ();

    int mismatches;
    int outstanding;
    int responses;

    int items_sent;
    int cfg_writes;
    int hist_reads;
    bit quiet;           // no random idling on either side while set
    bit long_hold_req;   // sender asks the response side for one long hold-off

    logic [15:0] distances [SETTINGS_COUNT];

    tof_sensor_register_model uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    tsrm_response_checker response_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_ch.valid),
        .req_ready           (req_ch.ready),
        .req_command         (req_ch.command),
        .req_pointer_present (req_ch.pointer_present),
        .req_reg_pointer     (req_ch.reg_pointer),
        .req_write_len       (req_ch.write_len),
        .req_read_len        (req_ch.read_len),
        .req_read_offset     (req_ch.read_offset),
        .rsp_valid           (rsp_ch.valid),
        .rsp_ready           (rsp_ch.ready),
        .rsp_read_data       (rsp_ch.read_data),
        .rsp_frame_count     (rsp_ch.frame_count),
        .cfg_valid           (cfg_ch.valid),
        .cfg_ready           (cfg_ch.ready),
        .cfg_distance_mm     (cfg_ch.distance_mm),
        .mismatches          (mismatches),
        .outstanding         (outstanding),
        .responses           (responses)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle gap length: mostly none or short, now and then a long one
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 94)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // One request transaction. Valid stays high on return unless an idle gap follows,
    // so back-to-back transactions never lower and raise valid in the same step.
    task automatic send_req(input logic cmd, input logic present, input logic [15:0] ptr,
                            input logic [7:0] wlen, input logic [7:0] rlen,
                            input logic [7:0] roff);
        int gap;
        req_ch.valid           <= 1'b1;
        req_ch.command         <= cmd;
        req_ch.pointer_present <= present;
        req_ch.reg_pointer     <= ptr;
        req_ch.write_len       <= wlen;
        req_ch.read_len        <= rlen;
        req_ch.read_offset     <= roff;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        gap = quiet ? 0 : idle_length();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Bytes 0..nbytes-1 of a read transaction of rlen bytes; the pointer goes with the first
    task automatic read_burst(input logic [15:0] ptr, input logic [7:0] rlen, input int nbytes);
        int off;
        for (off = 0; off < nbytes; off++)
        begin
            send_req(CMD_READ, off == 0, ptr, 8'($urandom_range(0, 255)), rlen, 8'(off));
        end
    endtask

    // Stop offering and wait until every predicted response has been taken. The extra edge
    // lets the checker count a transaction accepted at the edge where valid is lowered.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_distance(input logic [15:0] value);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.distance_mm <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly well-formed register accesses with random content, some pure noise
    task automatic random_traffic(input int count);
        int          target;
        int          kind;
        int          rlen;
        logic [15:0] ptr;
        target = items_sent + count;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 5)
            begin
                // full histogram block, sometimes with bytes past its end
                rlen = ($urandom_range(0, 3) == 0) ? $urandom_range(84, 100) : int'(HIST_LEN);
                read_burst(ADDR_HIST, 8'(rlen), rlen);
                hist_reads++;
            end
            else if (kind < 6)
            begin
                // histogram read too short to return data
                read_burst(ADDR_HIST, 8'($urandom_range(0, 82)), $urandom_range(1, 6));
            end
            else if (kind < 9)
            begin
                case ($urandom_range(0, 3))
                    0:       ptr = ADDR_STATUS;
                    1:       ptr = ADDR_READY;
                    2:       ptr = ADDR_OSC;
                    default: ptr = 16'($urandom_range(0, 16'h00FF));
                endcase
                rlen = $urandom_range(0, 4);
                read_burst(ptr, 8'(rlen), rlen + $urandom_range(1, 2));
            end
            else if (kind < 14)
            begin
                // writes clustered around the mode-start register
                ptr = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                      16'($urandom_range(16'h0070, 16'h0090));
                send_req(CMD_WRITE, $urandom_range(0, 4) != 0, ptr,
                         8'($urandom_range(0, 48)), 8'($urandom), 8'($urandom));
            end
            else
            begin
                send_req(1'($urandom), 1'($urandom), 16'($urandom), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 254)));
            end
        end
    endtask

    // Response side: random throttling, plus one long hold-off on request, counted here
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left == 0 && !quiet && $urandom_range(0, 3) == 0)
            begin
                hold_left = idle_length();
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int phase;
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.command         = CMD_WRITE;
        req_ch.pointer_present = 1'b0;
        req_ch.reg_pointer     = 16'h0000;
        req_ch.write_len       = 8'd0;
        req_ch.read_len        = 8'd0;
        req_ch.read_offset     = 8'd0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.distance_mm     = 16'd0;
        items_sent    = 0;
        cfg_writes    = 0;
        hist_reads    = 0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;

        // extremes and the tie-rounding zero among a spread of random settings
        distances[0] = 16'd1400;
        distances[1] = 16'hFFFF;
        distances[2] = 16'd1401;
        distances[3] = 16'($urandom_range(0, 1400));
        distances[4] = 16'd0;
        distances[5] = 16'($urandom_range(1401, 65535));
        distances[6] = 16'($urandom_range(0, 1400));
        distances[7] = 16'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset distance of 0 (peak phase lands exactly on a tie)
        // first start write wraps the stream count from 0xFF to 0
        send_req(CMD_WRITE, 1'b1, ADDR_START, 8'd3, 8'd0, 8'd0);
        // write too short to have a span
        send_req(CMD_WRITE, 1'b1, 16'h0080, 8'd1, 8'd0, 8'd0);
        // span wraps past 0xFFFF and must not count
        send_req(CMD_WRITE, 1'b1, 16'hFFFF, 8'd255, 8'd0, 8'd0);
        // widest span from zero; read fields are ignored on writes
        send_req(CMD_WRITE, 1'b1, 16'h0000, 8'd255, 8'd255, 8'd254);
        // no new pointer: span ends exactly at the start register, no count
        send_req(CMD_WRITE, 1'b0, 16'hFFFF, 8'h89, 8'd0, 8'd0);
        send_req(CMD_WRITE, 1'b1, 16'h0086, 8'd3, 8'd0, 8'd0);
        // status: first byte, second byte, byte outside the transaction
        read_burst(ADDR_STATUS, 8'd2, 3);
        read_burst(ADDR_READY, 8'd1, 1);
        // oscillator, full then short
        read_burst(ADDR_OSC, 8'd2, 2);
        send_req(CMD_READ, 1'b0, 16'h0000, 8'd0, 8'd1, 8'd0);
        // histogram too short
        read_burst(ADDR_HIST, 8'd82, 1);
        send_req(CMD_READ, 1'b0, 16'h0000, 8'd0, 8'd82, 8'd5);
        // histogram header, bins, trailer and bytes past the block
        send_req(CMD_READ, 1'b1, ADDR_HIST, 8'd0, 8'd255, 8'd0);
        send_req(CMD_READ, 1'b0, 16'h0000, 8'd0, 8'd255, 8'd3);
        send_req(CMD_READ, 1'b0, 16'h0000, 8'd0, 8'd255, 8'd6);
        send_req(CMD_READ, 1'b0, 16'h0000, 8'd0, 8'd255, 8'd8);
        send_req(CMD_READ, 1'b0, 16'h0000, 8'd0, 8'd255, 8'd81);
        send_req(CMD_READ, 1'b0, 16'h0000, 8'd0, 8'd255, 8'd82);
        send_req(CMD_READ, 1'b0, 16'h0000, 8'd0, 8'd255, 8'd83);
        send_req(CMD_READ, 1'b0, 16'h0000, 8'd0, 8'd255, 8'd254);
        // unmapped registers
        send_req(CMD_READ, 1'b1, 16'h1234, 8'd0, 8'd5, 8'd0);
        send_req(CMD_READ, 1'b1, 16'hFFFF, 8'd0, 8'd255, 8'd254);

        // Random part: one block of traffic per distance setting, fully drained before
        // each write. Settings 2 and 3 run without idling; setting 3 also holds the
        // response side off long enough to back the block up.
        for (phase = 0; phase < SETTINGS_COUNT; phase++)
        begin
            settle();
            write_distance(distances[phase]);
            quiet = (phase == 2 || phase == 3);
            if (phase == 3)
            begin
                long_hold_req = 1'b1;
            end
            random_traffic(RANDOM_ITEMS / SETTINGS_COUNT);
        end
        quiet = 1'b0;

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d request transactions and %0d responses over %0d distance writes,",
                 items_sent, responses, cfg_writes);
        $display("including %0d full histogram block reads and a %0d-cycle response hold-off.",
                 hist_reads, LONG_HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/tsrm_pkg.sv
hw/rtl/tsrm_if.sv
hw/rtl/tsrm_peak_bin.sv
hw/rtl/tof_sensor_register_model.sv
bench/tsrm_response_checker.sv
bench/tof_sensor_register_model_tb.sv
